// ===== rtl/uch_pkg.sv =====
// ----------------------------------------------------------------------------
// uch_pkg: shared types and constants of the UTF-8 character histogram
// Job format between the front and back parts, sizes, lead byte decode.
// ----------------------------------------------------------------------------
package uch_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = IDX_W + 1;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        JOB_NONE = 2'd0,   // byte taken, no character finished
        JOB_CHAR = 2'd1,   // finished character, look it up
        JOB_READ = 2'd2    // table read
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] key;
        logic [2:0]  len;
        logic [7:0]  idx;
    } t_job;

    // number of tail bytes announced by a lead byte
    function automatic logic [1:0] tail_of_lead(input logic [7:0] b);
        logic [1:0] t;
        t = 2'd0;
        if      ((b & LEAD2_MASK) == LEAD2_CODE) t = 2'd1;
        else if ((b & LEAD3_MASK) == LEAD3_CODE) t = 2'd2;
        else if ((b & LEAD4_MASK) == LEAD4_CODE) t = 2'd3;
        return t;
    endfunction

endpackage

// ===== rtl/uch_if.sv =====
// ----------------------------------------------------------------------------
// uch_if: channel interfaces of the UTF-8 character histogram
// Input word channel and result word channel, valid/ready.
// ----------------------------------------------------------------------------
interface uch_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_value;
    logic [7:0] read_index;

    modport source (output valid, op, byte_value, read_index, input ready);
    modport sink   (input valid, op, byte_value, read_index, output ready);
endinterface

interface uch_out_if;
    logic        valid;
    logic        ready;
    logic        char_done;
    logic [31:0] char_key;
    logic [2:0]  char_length;
    logic [7:0]  entry_slot;
    logic [31:0] entry_count;
    logic        entry_valid;
    logic [8:0]  distinct_count;
    logic        table_full;

    modport source (output valid, char_done, char_key, char_length, entry_slot,
                    entry_count, entry_valid, distinct_count, table_full,
                    input ready);
    modport sink   (input valid, char_done, char_key, char_length, entry_slot,
                    entry_count, entry_valid, distinct_count, table_full,
                    output ready);
endinterface

// ===== rtl/utf8_char_histogram.sv =====
// ----------------------------------------------------------------------------
// utf8_char_histogram: UTF-8 character frequency counter
// Splits a byte stream into characters and keeps a table of their counts.
// ----------------------------------------------------------------------------
// Channels: i_in takes one word per handshake (op, byte_value, read_index);
// o_out gives exactly one result word for every input word, in order.
// op feed: the byte is gathered; a finished character is looked up in the
// key table by a linear search, one entry read per cycle from the table
// RAM. A hit bumps the saturating count, a miss appends or sets table_full.
// op read: returns one table entry.
// Result path: a byte that finishes no character, or a read of an unused
// entry, is answered when the engine takes it from the queue; a read of a
// used entry goes through the registered table read; a character is
// answered once the search hits or passes the used entries, its wait set by
// the single read port of the key RAM walked during the search.
// Throughput: one word in flight in the table engine; the front gatherer and
// a two-word job queue keep taking input while it searches.
// Reset: clears the gatherer, queue, used count and full flag. Table RAM
// contents are not cleared; only entries below the used count are searched or returned.
// Receiver stall: the result word holds in its register, the engine waits,
// the queue fills and then i_in.ready drops.
// ----------------------------------------------------------------------------
module utf8_char_histogram (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uch_in_if.sink    i_in,
    uch_out_if.source o_out
);
    import uch_pkg::*;

    t_job q_in_job, q_out_job;
    logic q_push, q_full, q_pop, q_valid;

    uch_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in_job)
    );

    uch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    uch_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_out_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/uch_queue.sv =====
// ----------------------------------------------------------------------------
// uch_queue: two-entry job queue
// Decouples the byte front end from the table back end.
// ----------------------------------------------------------------------------
module uch_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uch_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output uch_pkg::t_job o_job
);
    import uch_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== rtl/uch_front.sv =====
// ----------------------------------------------------------------------------
// uch_front: byte gatherer
// Splits the byte stream into UTF-8 characters and emits one job per word.
// ----------------------------------------------------------------------------
module uch_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uch_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output uch_pkg::t_job o_job
);
    import uch_pkg::*;

    logic [31:0] r_gather, n_gather;
    logic [1:0]  r_rem, n_rem;
    logic [2:0]  r_glen, n_glen;
    logic        r_collect, n_collect;
    logic [31:0] merged;
    logic [1:0]  tail;

    assign i_in.ready = ~i_q_full;
    assign o_push     = i_in.valid & ~i_q_full;

    always_comb begin
        tail   = tail_of_lead(i_in.byte_value);
        merged = r_gather;
        unique case (r_glen[1:0])
            2'd1:    merged[23:16] = i_in.byte_value;
            2'd2:    merged[15:8]  = i_in.byte_value;
            2'd3:    merged[7:0]   = i_in.byte_value;
            default: merged[31:24] = i_in.byte_value;
        endcase

        n_gather  = r_gather;
        n_rem     = r_rem;
        n_glen    = r_glen;
        n_collect = r_collect;
        o_job     = '{kind: JOB_NONE, key: '0, len: '0, idx: i_in.read_index};

        if (i_in.op == OP_READ) begin
            o_job.kind = JOB_READ;
        end else if (!r_collect) begin
            if (tail == 2'd0) begin
                o_job.kind = JOB_CHAR;
                o_job.key  = {i_in.byte_value, 24'd0};
                o_job.len  = 3'd1;
            end else begin
                n_gather  = {i_in.byte_value, 24'd0};
                n_rem     = tail;
                n_glen    = 3'd1;
                n_collect = 1'b1;
            end
        end else begin
            if (r_rem == 2'd1 || r_glen >= 3'd3) begin
                o_job.kind = JOB_CHAR;
                o_job.key  = merged;
                o_job.len  = r_glen + 3'd1;
                n_gather   = '0;
                n_rem      = '0;
                n_glen     = '0;
                n_collect  = 1'b0;
            end else begin
                n_gather = merged;
                n_rem    = r_rem - 2'd1;
                n_glen   = r_glen + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather  <= '0;
            r_rem     <= '0;
            r_glen    <= '0;
            r_collect <= 1'b0;
        end else if (o_push) begin
            r_gather  <= n_gather;
            r_rem     <= n_rem;
            r_glen    <= n_glen;
            r_collect <= n_collect;
        end
    end

endmodule

// ===== rtl/uch_back.sv =====
// ----------------------------------------------------------------------------
// uch_back: table engine
// Linear search, count update, append and entry read over the key table.
// ----------------------------------------------------------------------------
module uch_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  uch_pkg::t_job i_job,
    output logic          o_pop,
    uch_out_if.source     o_out
);
    import uch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_READ   = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    logic [31:0]            r_keys [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_cnts [TABLE_DEPTH];

    t_state                 r_state, n_state;
    t_job                   r_job;
    logic [USED_W-1:0]      r_used;
    logic                   r_full;
    logic [USED_W-1:0]      r_addr;
    logic                   r_chk;
    logic [IDX_W-1:0]       r_chk_idx;
    logic [31:0]            r_key_q;
    logic [COUNT_WIDTH-1:0] r_cnt_q;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   we;
    logic [IDX_W-1:0]       wr_addr;
    logic                   wr_key_en;
    logic [COUNT_WIDTH-1:0] wr_cnt;

    logic        r_ov, r_done, r_evalid;
    logic [31:0] r_okey, r_ocnt;
    logic [2:0]  r_olen;
    logic [7:0]  r_oslot;

    logic hit, search_end, take;

    assign take       = (r_state == S_IDLE) && i_q_valid && !r_ov;
    assign o_pop      = take;
    assign hit        = r_chk && (r_key_q == r_job.key);
    assign search_end = !r_chk && (r_addr >= r_used);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr[IDX_W-1:0];
        if (take && i_job.kind == JOB_READ) begin
            rd_en   = 1'b1;
            rd_addr = i_job.idx[IDX_W-1:0];
        end else if (r_state == S_SEARCH && !hit && r_addr < r_used) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        we        = 1'b0;
        wr_key_en = 1'b0;
        wr_addr   = r_chk_idx;
        wr_cnt    = r_cnt_q + COUNT_WIDTH'(1);
        if (r_state == S_SEARCH) begin
            if (hit) begin
                we = (r_cnt_q != '1);
            end else if (search_end && r_used < USED_W'(TABLE_DEPTH)) begin
                we        = 1'b1;
                wr_key_en = 1'b1;
                wr_addr   = r_used[IDX_W-1:0];
                wr_cnt    = COUNT_WIDTH'(1);
            end
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) r_cnts[wr_addr] <= wr_cnt;
        if (wr_key_en) r_keys[wr_addr] <= r_job.key;
        if (rd_en) begin
            r_key_q <= r_keys[rd_addr];
            r_cnt_q <= r_cnts[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_job.kind == JOB_CHAR) n_state = S_SEARCH;
                else if (take && i_job.kind == JOB_READ
                         && {1'b0, i_job.idx} < r_used) n_state = S_READ;
            end
            S_SEARCH: if (hit || search_end) n_state = S_HOLD;
            S_READ:   n_state = S_HOLD;
            S_HOLD:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) r_job <= i_job;
        if (take) begin
            r_addr <= '0;
            r_chk  <= 1'b0;
        end else if (rd_en) begin
            r_addr    <= r_addr + USED_W'(1);
            r_chk     <= 1'b1;
            r_chk_idx <= r_addr[IDX_W-1:0];
        end else begin
            r_chk <= 1'b0;
        end
    end

    // result word and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_full  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            if (take && i_job.kind == JOB_NONE) begin
                r_ov <= 1'b1; r_done <= 1'b0; r_okey <= '0; r_olen <= '0;
                r_oslot <= '0; r_ocnt <= '0; r_evalid <= 1'b0;
            end
            if (take && i_job.kind == JOB_READ && {1'b0, i_job.idx} >= r_used) begin
                r_ov <= 1'b1; r_done <= 1'b0; r_okey <= '0; r_olen <= '0;
                r_oslot <= i_job.idx; r_ocnt <= '0; r_evalid <= 1'b0;
            end
            if (r_state == S_READ) begin
                r_ov     <= 1'b1;
                r_done   <= 1'b0;
                r_okey   <= r_key_q;
                r_olen   <= {1'b0, tail_of_lead(r_key_q[31:24])} + 3'd1;
                r_oslot  <= r_job.idx;
                r_ocnt   <= r_cnt_q;
                r_evalid <= 1'b1;
            end
            if (r_state == S_SEARCH && (hit || search_end)) begin
                r_ov   <= 1'b1;
                r_done <= 1'b1;
                r_okey <= r_job.key;
                r_olen <= r_job.len;
                if (hit) begin
                    r_oslot  <= 8'(r_chk_idx);
                    r_ocnt   <= (r_cnt_q != '1) ? wr_cnt : r_cnt_q;
                    r_evalid <= 1'b1;
                end else if (r_used < USED_W'(TABLE_DEPTH)) begin
                    r_oslot  <= 8'(r_used[IDX_W-1:0]);
                    r_ocnt   <= 32'd1;
                    r_evalid <= 1'b1;
                    r_used   <= r_used + USED_W'(1);
                end else begin
                    r_oslot  <= '0;
                    r_ocnt   <= '0;
                    r_evalid <= 1'b0;
                    r_full   <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.char_done      = r_done;
    assign o_out.char_key       = r_okey;
    assign o_out.char_length    = r_olen;
    assign o_out.entry_slot     = r_oslot;
    assign o_out.entry_count    = r_ocnt;
    assign o_out.entry_valid    = r_evalid;
    assign o_out.distinct_count = 9'(r_used);
    assign o_out.table_full     = r_full;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH)) else $error("used count past depth");
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> r_used == USED_W'(TABLE_DEPTH))
        else $error("full flag set with room left");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_used != $past(r_used) |-> r_used == $past(r_used) + 1'b1)
        else $error("used count jumped");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_ov) else $error("job taken while result pending");

endmodule
